// ===== hw/rtl/mhsi_pkg.sv =====
// Package of shared constants, types and codes for the magnetometer calibration block.
package mhsi_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int ACCEL_W         = 15;
    localparam int CFG_W           = 16;
    localparam int OUT_W           = 16;
    localparam int GAIN_FRAC       = 12;
    localparam int AXES            = 3;

    localparam logic [CFG_W-1:0]          SPR_RESET    = 16'd2000;
    localparam logic signed [ACCEL_W-1:0] THRESH_RESET = -15'sd976;

    typedef enum logic [0:0] {
        REG_SAMPLES_PER_RUN = 1'b0,
        REG_LEVEL_THRESHOLD = 1'b1
    } cfg_reg_t;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_PREP,
        ST_DIV_INIT,
        ST_DIV,
        ST_LOAD
    } ctrl_state_t;

    typedef struct packed {
        logic       take;
        logic       snap;
        logic       div_init;
        logic       div_step;
        logic       div_last;
        logic [1:0] axis;
        logic       load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic run_end;
        logic degen;
    } dp_status_t;

endpackage

// ===== hw/rtl/mhsi_in_if.sv =====
// Input channel interface: one magnetometer sample and a vertical acceleration reading.
interface mhsi_in_if
    import mhsi_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] mag_x;
    logic signed [SAMPLE_BITS-1:0] mag_y;
    logic signed [SAMPLE_BITS-1:0] mag_z;
    logic signed [ACCEL_W-1:0]     accel_vertical;

    modport source (output valid, output mag_x, output mag_y, output mag_z,
                    output accel_vertical, input ready);
    modport sink   (input valid, input mag_x, input mag_y, input mag_z,
                    input accel_vertical, output ready);
endinterface

// ===== hw/rtl/mhsi_out_if.sv =====
// Result channel interface: bias, gain, used sample count and degenerate flag of one run.
interface mhsi_out_if
    import mhsi_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] bias_x;
    logic signed [OUT_W-1:0] bias_y;
    logic signed [OUT_W-1:0] bias_z;
    logic [OUT_W-1:0]        gain_x;
    logic [OUT_W-1:0]        gain_y;
    logic [OUT_W-1:0]        gain_z;
    logic [OUT_W-1:0]        used_samples;
    logic                    degenerate;

    modport source (output valid, output bias_x, output bias_y, output bias_z,
                    output gain_x, output gain_y, output gain_z,
                    output used_samples, output degenerate, input ready);
    modport sink   (input valid, input bias_x, input bias_y, input bias_z,
                    input gain_x, input gain_y, input gain_z,
                    input used_samples, input degenerate, output ready);
endinterface

// ===== hw/rtl/mhsi_ctrl.sv =====
// Controller state machine: sample acceptance, run end, per-axis division sequencing, result load.
module mhsi_ctrl
    import mhsi_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);
    localparam int NUM_W  = SAMPLE_BITS + 13;
    localparam int BCNT_W = $clog2(NUM_W);

    ctrl_state_t       state_reg, state_next;
    logic [BCNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [1:0]        axis_reg, axis_next;
    logic              out_valid_reg, out_valid_next;
    logic              bit_last;
    logic              slot_free;

    assign bit_last  = (bit_cnt_reg == BCNT_W'(NUM_W - 1));
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        axis_next    = axis_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (in_valid && status.run_end)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                axis_next  = AXIS_X;
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                bit_cnt_next = '0;
                state_next   = status.degen ? ST_LOAD : ST_DIV;
            end
            ST_DIV:
            begin
                bit_cnt_next = bit_cnt_reg + BCNT_W'(1);
                if (bit_last)
                begin
                    if (axis_reg == AXIS_Z)
                        state_next = ST_LOAD;
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_DIV_INIT;
                    end
                end
            end
            ST_LOAD:
            begin
                if (slot_free)
                    state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.axis     = axis_reg;
        cmd.div_last = bit_last;
        unique case (state_reg)
            ST_RUN:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_PREP:     cmd.snap     = 1'b1;
            ST_DIV_INIT: cmd.div_init = !status.degen;
            ST_DIV:      cmd.div_step = 1'b1;
            ST_LOAD:     cmd.load     = slot_free;
            default:     cmd.take     = 1'b0;
        endcase
    end

    always_comb
    begin
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            bit_cnt_reg   <= '0;
            axis_reg      <= AXIS_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/mhsi_datapath.sv =====
// Datapath: configuration, extreme tracking, run snapshot, bit-serial divider and result register.
module mhsi_datapath
    import mhsi_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  cfg_reg_t                      cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] mag_x,
    input  logic signed [SAMPLE_BITS-1:0] mag_y,
    input  logic signed [SAMPLE_BITS-1:0] mag_z,
    input  logic signed [ACCEL_W-1:0]     accel_vertical,
    input  ctrl_cmd_t                     cmd,
    output dp_status_t                    status,
    output logic signed [OUT_W-1:0]       bias_x,
    output logic signed [OUT_W-1:0]       bias_y,
    output logic signed [OUT_W-1:0]       bias_z,
    output logic [OUT_W-1:0]              gain_x,
    output logic [OUT_W-1:0]              gain_y,
    output logic [OUT_W-1:0]              gain_z,
    output logic [OUT_W-1:0]              used_samples,
    output logic                          degenerate
);
    localparam int B     = SAMPLE_BITS;
    localparam int NUM_W = B + 13;
    localparam int EXT_W = (B > OUT_W) ? B : OUT_W;

    localparam logic signed [B-1:0] MAX_INIT = {1'b1, {(B-1){1'b0}}};
    localparam logic signed [B-1:0] MIN_INIT = {1'b0, {(B-1){1'b1}}};

    logic [CFG_W-1:0]          spr_reg;
    logic signed [ACCEL_W-1:0] thr_reg;

    logic signed [B-1:0] max_reg  [AXES];
    logic signed [B-1:0] min_reg  [AXES];
    logic [OUT_W-1:0]    item_cnt_reg;
    logic [OUT_W-1:0]    level_cnt_reg;

    logic signed [B-1:0] bias_reg [AXES];
    logic signed [B-1:0] half_reg [AXES];
    logic [B:0]          sum_reg;
    logic [OUT_W-1:0]    used_reg;
    logic                degen_reg;

    logic [B:0]          rem_reg;
    logic [NUM_W-1:0]    quo_reg;
    logic [OUT_W-1:0]    gain_reg [AXES];

    logic signed [B-1:0] samp     [AXES];
    logic signed [B-1:0] bias_c   [AXES];
    logic signed [B-1:0] half_c   [AXES];
    logic signed [B:0]   mid_sum;
    logic signed [B:0]   span;
    logic signed [B:0]   mid_adj;
    logic signed [B:0]   span_adj;
    logic signed [B+1:0] hsum;
    logic                degen_c;
    logic                level;

    logic [B-1:0]        h_sel;
    logic [B:0]          den;
    logic [B+1:0]        trial;
    logic [B:0]          rem_next;
    logic [NUM_W-1:0]    quo_next;
    logic [OUT_W-1:0]    gain_sat;

    logic signed [EXT_W-1:0] bias_ext [AXES];

    assign samp[0] = mag_x;
    assign samp[1] = mag_y;
    assign samp[2] = mag_z;

    assign level          = (accel_vertical < thr_reg);
    assign status.run_end = ((item_cnt_reg + 16'd1) >= spr_reg);
    assign status.degen   = degen_reg;

    // Midpoint and half-range per axis, both halved with truncation toward zero.
    always_comb
    begin
        degen_c = 1'b0;
        hsum    = '0;
        for (int a = 0; a < AXES; a++)
        begin
            mid_sum   = {max_reg[a][B-1], max_reg[a]} + {min_reg[a][B-1], min_reg[a]};
            span      = {max_reg[a][B-1], max_reg[a]} - {min_reg[a][B-1], min_reg[a]};
            mid_adj   = mid_sum + {{B{1'b0}}, mid_sum[B]};
            span_adj  = span + {{B{1'b0}}, span[B]};
            bias_c[a] = mid_adj[B:1];
            half_c[a] = span_adj[B:1];
            if (half_c[a][B-1] || (half_c[a] == '0))
                degen_c = 1'b1;
            hsum = hsum + {{2{half_c[a][B-1]}}, half_c[a]};
        end
    end

    // Divisor is three times the selected half-range, which is positive here.
    always_comb
    begin
        unique case (cmd.axis)
            AXIS_X:  h_sel = half_reg[0];
            AXIS_Y:  h_sel = half_reg[1];
            AXIS_Z:  h_sel = half_reg[2];
            default: h_sel = half_reg[0];
        endcase
        den = {1'b0, h_sel} + {h_sel, 1'b0};
    end

    // One restoring division step per cycle.
    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]} - {1'b0, den};
        if (!trial[B+1])
        begin
            rem_next = trial[B:0];
            quo_next = {quo_reg[NUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = {rem_reg[B-1:0], quo_reg[NUM_W-1]};
            quo_next = {quo_reg[NUM_W-2:0], 1'b0};
        end
        gain_sat = (|quo_next[NUM_W-1:OUT_W]) ? {OUT_W{1'b1}} : quo_next[OUT_W-1:0];
    end

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
            bias_ext[a] = EXT_W'(bias_reg[a]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg <= SPR_RESET;
            thr_reg <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SAMPLES_PER_RUN: spr_reg <= cfg_data;
                REG_LEVEL_THRESHOLD: thr_reg <= cfg_data[ACCEL_W-1:0];
                default:             spr_reg <= spr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                max_reg[a] <= MAX_INIT;
                min_reg[a] <= MIN_INIT;
            end
            item_cnt_reg  <= '0;
            level_cnt_reg <= '0;
        end
        else if (cmd.snap)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                max_reg[a] <= MAX_INIT;
                min_reg[a] <= MIN_INIT;
            end
            item_cnt_reg  <= '0;
            level_cnt_reg <= '0;
        end
        else if (cmd.take)
        begin
            item_cnt_reg <= item_cnt_reg + 16'd1;
            if (level)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    if (samp[a] > max_reg[a])
                        max_reg[a] <= samp[a];
                    if (samp[a] < min_reg[a])
                        min_reg[a] <= samp[a];
                end
                if (level_cnt_reg != {OUT_W{1'b1}})
                    level_cnt_reg <= level_cnt_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.snap)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                bias_reg[a] <= bias_c[a];
                half_reg[a] <= half_c[a];
                gain_reg[a] <= '0;
            end
            sum_reg   <= hsum[B:0];
            used_reg  <= level_cnt_reg;
            degen_reg <= degen_c;
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            quo_reg <= {sum_reg, {GAIN_FRAC{1'b0}}};
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            if (cmd.div_last)
            begin
                unique case (cmd.axis)
                    AXIS_X:  gain_reg[0] <= gain_sat;
                    AXIS_Y:  gain_reg[1] <= gain_sat;
                    AXIS_Z:  gain_reg[2] <= gain_sat;
                    default: gain_reg[0] <= gain_sat;
                endcase
            end
        end
        if (cmd.load)
        begin
            bias_x       <= bias_ext[0][OUT_W-1:0];
            bias_y       <= bias_ext[1][OUT_W-1:0];
            bias_z       <= bias_ext[2][OUT_W-1:0];
            gain_x       <= gain_reg[0];
            gain_y       <= gain_reg[1];
            gain_z       <= gain_reg[2];
            used_samples <= used_reg;
            degenerate   <= degen_reg;
        end
    end

endmodule

// ===== hw/rtl/magnetometer_hard_soft_iron_calibration.sv =====
// Top level of the magnetometer min/max hard-iron and soft-iron calibration block.
//
// sample_ch takes one transaction per magnetometer sample (three axes plus vertical
// acceleration). Samples taken while the acceleration is below level_threshold update
// the per-axis maximum and minimum; every sample advances the item count. The
// configuration port writes samples_per_run and level_threshold by index.
// Ordinary samples are taken one per cycle. The sample that ends a run starts the
// result computation: a snapshot state, then for each axis a set-up state and a
// bit-serial restoring divider with a (SAMPLE_BITS + 13)-bit quotient, then a load
// state; sample_ch.ready is low throughout. A degenerate run skips the divider,
// going from the first set-up state straight to the load state.
// The result goes to a register on result_ch; a new run may start while it waits.
// If the receiver stalls, a second finished result waits in the load state until
// the first transaction completes, holding sample_ch.ready low.
// Reset clears the extremes and counters, loads the register defaults (2000 samples,
// -976 milli-g) and leaves result_ch empty.
module magnetometer_hard_soft_iron_calibration
    import mhsi_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  cfg_reg_t         cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    mhsi_in_if.sink          sample_ch,
    mhsi_out_if.source       result_ch
);
    ctrl_cmd_t  cmd;
    dp_status_t status;

    mhsi_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_ch.valid),
        .in_ready  (sample_ch.ready),
        .out_valid (result_ch.valid),
        .out_ready (result_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mhsi_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mag_x          (sample_ch.mag_x),
        .mag_y          (sample_ch.mag_y),
        .mag_z          (sample_ch.mag_z),
        .accel_vertical (sample_ch.accel_vertical),
        .cmd            (cmd),
        .status         (status),
        .bias_x         (result_ch.bias_x),
        .bias_y         (result_ch.bias_y),
        .bias_z         (result_ch.bias_z),
        .gain_x         (result_ch.gain_x),
        .gain_y         (result_ch.gain_y),
        .gain_z         (result_ch.gain_z),
        .used_samples   (result_ch.used_samples),
        .degenerate     (result_ch.degenerate)
    );

    // A run-ending transaction is followed at once by the snapshot.
    a_run_end_snap: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_ch.valid && sample_ch.ready && status.run_end) |=> cmd.snap)
        else $error("run end not followed by snapshot");

    // No sample is taken while the extremes are being captured and cleared.
    a_snap_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.snap |-> !sample_ch.ready)
        else $error("sample taken during snapshot");

    // A result is only loaded into a free output register.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!result_ch.valid || result_ch.ready))
        else $error("result overwritten before transaction");

    // A degenerate run reports zero gains on every axis.
    a_degen_gain: assert property (@(posedge clk) disable iff (!rst_n)
        (result_ch.valid && result_ch.degenerate) |->
            (result_ch.gain_x == '0 && result_ch.gain_y == '0 && result_ch.gain_z == '0))
        else $error("degenerate result with non-zero gain");

endmodule
